// ===== hw/rtl/buddy_block_allocator_macros.svh =====
// Assertion macros for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define BBA_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("buddy allocator check failed");
`define BBA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("buddy allocator check failed");
`else
`define BBA_ASSERT_SAME(name, ante, cons)
`define BBA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hw/rtl/bba_pkg.sv =====
// Shared constants and codes of the buddy block allocator.
`default_nettype none
package bba_pkg;
   localparam int LEVEL_COUNT_DEF = 11;

   localparam logic [63:0] BASE_RESET   = 64'd0;
   localparam logic [4:0]  LEAF_RESET   = 5'd12;
   localparam logic [3:0]  LEVELS_RESET = 4'd10;

   typedef enum logic [1:0] {
      CSR_BASE   = 2'd0,
      CSR_LEAF   = 2'd1,
      CSR_LEVELS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      FN_ALLOC      = 3'd0,
      FN_FREE_SPLIT = 3'd1,
      FN_FREE_SIZE  = 3'd2,
      FN_FREE_LEVEL = 3'd3,
      FN_QUERY      = 3'd4
   } func_type;

   // bit positions in a bitmap word
   localparam int BIT_PAIR  = 0;
   localparam int BIT_SPLIT = 1;
endpackage
`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// Simple dual-port RAM with registered read data.
`default_nettype none
module bba_ram #(
   parameter int WIDTH  = 2,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [1 << ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: sequencer, free lists and result register.
`default_nettype none
`include "buddy_block_allocator_macros.svh"
// Binary buddy allocator over a region of 2^(leaf_shift+levels_in_use) bytes. One request
// is taken at a time; req_tready is low until its result has been handed to the result
// register, which then waits for rsp_tready while the next request may enter. Rounding a
// size up scans one bit position a cycle, finding a block's level reads the split bits
// one level at a time, and each split or merge level is a run of states, set by the single
// read and write port of the bitmap RAM and of the two link RAMs. After reset and after
// every write to the base, leaf or levels register the bitmap and link RAMs are cleared
// one word a cycle, all 2^(LEVEL_COUNT-1) words (1024 by default), and no request is
// taken meanwhile.
module buddy_block_allocator #(
   parameter int LEVEL_COUNT = bba_pkg::LEVEL_COUNT_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // request_size[30:0], block_address[94:31], free_level[98:95], zero fill
   input  wire logic [103:0] req_tdata,
   // func[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_address[63:0], block_bytes[94:64], free_bytes[125:95], zero fill
   output logic      [127:0] rsp_tdata,
   // success[0]
   output logic      [0:0]   rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);
   localparam int L   = LEVEL_COUNT;
   localparam int IW  = L - 1;
   localparam int LVW = $clog2(L);

   typedef enum logic [25:0] {
      ST_CLEAR    = 26'd1 << 0,
      ST_IDLE     = 26'd1 << 1,
      ST_DECODE   = 26'd1 << 2,
      ST_SIZE     = 26'd1 << 3,
      ST_LEVEL    = 26'd1 << 4,
      ST_ALLOC    = 26'd1 << 5,
      ST_SEARCH   = 26'd1 << 6,
      ST_POP_RD   = 26'd1 << 7,
      ST_POP_WR   = 26'd1 << 8,
      ST_SPLIT_RD = 26'd1 << 9,
      ST_SPLIT_WR = 26'd1 << 10,
      ST_SFLIP_RD = 26'd1 << 11,
      ST_SFLIP_WR = 26'd1 << 12,
      ST_PUSH_A   = 26'd1 << 13,
      ST_PUSH_B   = 26'd1 << 14,
      ST_AFLIP_RD = 26'd1 << 15,
      ST_AFLIP_WR = 26'd1 << 16,
      ST_ADONE    = 26'd1 << 17,
      ST_SL_RD    = 26'd1 << 18,
      ST_SL_CHK   = 26'd1 << 19,
      ST_REL_INIT = 26'd1 << 20,
      ST_REL_RD   = 26'd1 << 21,
      ST_REL_WR   = 26'd1 << 22,
      ST_UNL_RD   = 26'd1 << 23,
      ST_UNL_WR   = 26'd1 << 24,
      ST_FINISH   = 26'd1 << 25
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] base_ff, base_in;
   logic [4:0]  leaf_ff, leaf_in;
   logic [3:0]  levels_ff, levels_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [L-1:0] heads_ff [L];
   logic [L-1:0] heads_in [L];
   logic [L-1:0] cnt_ff [L];
   logic [L-1:0] cnt_in [L];
   logic [30:0] free_ff, free_in;

   logic [2:0]  func_ff, func_in;
   logic [30:0] req_ff, req_in;
   logic [63:0] off_ff, off_in;
   logic [3:0]  flv_ff, flv_in;
   logic [IW-1:0] b_ff, b_in;
   logic [LVW-1:0] lvl_ff, lvl_in;
   logic [LVW-1:0] cur_ff, cur_in;
   logic [4:0]  p_ff, p_in;
   logic [IW-1:0] push_b_ff, push_b_in;
   logic [LVW-1:0] push_lv_ff, push_lv_in;
   logic        rel_ff, rel_in;
   logic [63:0] res_addr_ff, res_addr_in;
   logic        res_ok_ff, res_ok_in;
   logic [30:0] res_bytes_ff, res_bytes_in;
   logic [63:0] rsp_addr_ff, rsp_addr_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [30:0] rsp_bytes_ff, rsp_bytes_in;
   logic [30:0] rsp_free_ff, rsp_free_in;

   logic          bm_we;
   logic [IW-1:0] bm_waddr, bm_raddr;
   logic [1:0]    bm_wdata, bm_rdata;
   logic          nx_we, pv_we;
   logic [IW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr;
   logic [L-1:0]  nx_wdata, nx_rdata, pv_wdata, pv_rdata;

   logic [LVW-1:0] eff_e;
   logic [4:0]     eff_s;
   logic [4:0]     reg_r;
   logic [30:0]    region;

   function automatic logic [IW-1:0] node_at(input logic [LVW-1:0] lv,
                                             input logic [IW-1:0] idx);
      logic [IW:0] t;
      t = (IW+1)'(1) << lv;
      t = t + {1'b0, idx} - (IW+1)'(1);
      return t[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] pos_at(input logic [IW-1:0] b,
                                            input logic [LVW-1:0] e,
                                            input logic [LVW-1:0] lv);
      return b >> (e - lv);
   endfunction

   function automatic logic [L-1:0] cnt_up(input logic [L-1:0] c);
      return (c == {L{1'b1}}) ? c : c + L'(1);
   endfunction

   function automatic logic [L-1:0] cnt_down(input logic [L-1:0] c);
      return (c == '0) ? c : c - L'(1);
   endfunction

   // effective geometry
   always_comb begin
      if (8'(levels_ff) > 8'(L - 1)) begin
         eff_e = LVW'(L - 1);
      end else begin
         eff_e = LVW'(levels_ff);
      end
      if (6'(leaf_ff) + 6'(eff_e) > 6'd30) begin
         eff_s = 5'(6'd30 - 6'(eff_e));
      end else begin
         eff_s = leaf_ff;
      end
      reg_r  = 5'(6'(eff_s) + 6'(eff_e));
      region = 31'(32'd1 << reg_r);
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      logic [30:0]    sz;
      logic [LVW-1:0] lv;
      logic [31:0]    tsum;
      logic [L-1:0]   hd;
      logic [IW-1:0]  span;
      logic [IW-1:0]  baln;
      state_in     = state_ff;
      base_in      = base_ff;
      leaf_in      = leaf_ff;
      levels_in    = levels_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      heads_in     = heads_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      func_in      = func_ff;
      req_in       = req_ff;
      off_in       = off_ff;
      flv_in       = flv_ff;
      b_in         = b_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      p_in         = p_ff;
      push_b_in    = push_b_ff;
      push_lv_in   = push_lv_ff;
      rel_in       = rel_ff;
      res_addr_in  = res_addr_ff;
      res_ok_in    = res_ok_ff;
      res_bytes_in = res_bytes_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_free_in  = rsp_free_ff;
      bm_we    = 1'b0;
      bm_waddr = '0;
      bm_wdata = '0;
      bm_raddr = '0;
      nx_we    = 1'b0;
      nx_waddr = '0;
      nx_wdata = '0;
      nx_raddr = '0;
      pv_we    = 1'b0;
      pv_waddr = '0;
      pv_wdata = '0;
      pv_raddr = '0;
      sz   = (req_ff == '0) ? 31'd1 : req_ff;
      lv   = '0;
      tsum = '0;
      hd   = heads_ff[push_lv_ff];
      span = IW'(1) << (eff_e - cur_ff);
      baln = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            bm_we    = 1'b1;
            bm_waddr = clr_ff;
            nx_we    = 1'b1;
            nx_waddr = clr_ff;
            pv_we    = 1'b1;
            pv_waddr = clr_ff;
            for (int i = 0; i < L; i++) begin
               heads_in[i] = '0;
               cnt_in[i]   = '0;
            end
            heads_in[0] = {1'b1, IW'(0)};
            cnt_in[0]   = L'(1);
            free_in     = region;
            clr_in      = clr_ff + IW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               req_in   = req_tdata[30:0];
               off_in   = req_tdata[94:31] - base_ff;
               flv_in   = req_tdata[98:95];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_addr_in  = '0;
            res_ok_in    = 1'b0;
            res_bytes_in = '0;
            p_in         = '0;
            state_in     = ST_FINISH;
            if (func_ff == bba_pkg::FN_ALLOC) begin
               state_in = ST_SIZE;
            end else if ((func_ff == bba_pkg::FN_FREE_SPLIT ||
                          func_ff == bba_pkg::FN_FREE_SIZE ||
                          func_ff == bba_pkg::FN_FREE_LEVEL ||
                          func_ff == bba_pkg::FN_QUERY) && off_ff < 64'(region)) begin
               b_in = IW'(off_ff >> eff_s);
               if (func_ff == bba_pkg::FN_FREE_SIZE) begin
                  state_in = ST_SIZE;
               end else if (func_ff == bba_pkg::FN_FREE_LEVEL) begin
                  if (8'(flv_ff) <= 8'(eff_e)) begin
                     cur_in   = LVW'(flv_ff);
                     state_in = ST_REL_INIT;
                  end
               end else begin
                  cur_in   = eff_e;
                  state_in = ST_SL_RD;
               end
            end
         end
         ST_SIZE: begin
            // advance one bit position of the round-up a cycle
            if (p_ff < 5'd31 && (32'd1 << p_ff) < {1'b0, sz}) begin
               p_in = p_ff + 5'd1;
            end else begin
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            if (p_ff > reg_r) begin
               state_in = ST_FINISH;
            end else begin
               lv = (p_ff < eff_s) ? eff_e : LVW'(reg_r - p_ff);
               if (func_ff == bba_pkg::FN_ALLOC) begin
                  lvl_in   = lv;
                  state_in = ST_ALLOC;
               end else begin
                  cur_in   = lv;
                  state_in = ST_REL_INIT;
               end
            end
         end
         ST_ALLOC: begin
            if ((region >> lvl_ff) > free_ff) begin
               state_in = ST_FINISH;
            end else if (heads_ff[lvl_ff][IW]) begin
               b_in     = heads_ff[lvl_ff][IW-1:0];
               cur_in   = lvl_ff;
               state_in = ST_POP_RD;
            end else if (lvl_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cur_in   = lvl_ff - LVW'(1);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (heads_ff[cur_ff][IW]) begin
               b_in     = heads_ff[cur_ff][IW-1:0];
               state_in = ST_POP_RD;
            end else if (cur_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cur_in = cur_ff - LVW'(1);
            end
         end
         ST_POP_RD: begin
            nx_raddr = b_ff;
            state_in = ST_POP_WR;
         end
         ST_POP_WR: begin
            if (nx_rdata[IW]) begin
               pv_we    = 1'b1;
               pv_waddr = nx_rdata[IW-1:0];
            end
            heads_in[cur_ff] = nx_rdata;
            cnt_in[cur_ff]   = cnt_down(cnt_ff[cur_ff]);
            state_in = (cur_ff < lvl_ff) ? ST_SPLIT_RD : ST_AFLIP_RD;
         end
         ST_SPLIT_RD: begin
            bm_raddr = node_at(cur_ff, pos_at(b_ff, eff_e, cur_ff));
            state_in = ST_SPLIT_WR;
         end
         ST_SPLIT_WR: begin
            bm_we    = 1'b1;
            bm_waddr = node_at(cur_ff, pos_at(b_ff, eff_e, cur_ff));
            bm_wdata = bm_rdata | (2'b1 << bba_pkg::BIT_SPLIT);
            push_b_in  = b_ff + (IW'(1) << (eff_e - cur_ff - LVW'(1)));
            push_lv_in = cur_ff + LVW'(1);
            rel_in     = 1'b0;
            state_in   = (cur_ff != '0) ? ST_SFLIP_RD : ST_PUSH_A;
         end
         ST_SFLIP_RD: begin
            bm_raddr = node_at(cur_ff - LVW'(1), pos_at(b_ff, eff_e, cur_ff) >> 1);
            state_in = ST_SFLIP_WR;
         end
         ST_SFLIP_WR: begin
            bm_we    = 1'b1;
            bm_waddr = node_at(cur_ff - LVW'(1), pos_at(b_ff, eff_e, cur_ff) >> 1);
            bm_wdata = bm_rdata ^ (2'b1 << bba_pkg::BIT_PAIR);
            state_in = ST_PUSH_A;
         end
         ST_PUSH_A: begin
            if (hd[IW]) begin
               pv_we    = 1'b1;
               pv_waddr = hd[IW-1:0];
               pv_wdata = {1'b1, push_b_ff};
            end
            nx_we    = 1'b1;
            nx_waddr = push_b_ff;
            nx_wdata = hd;
            state_in = ST_PUSH_B;
         end
         ST_PUSH_B: begin
            pv_we    = 1'b1;
            pv_waddr = push_b_ff;
            heads_in[push_lv_ff] = {1'b1, push_b_ff};
            cnt_in[push_lv_ff]   = cnt_up(cnt_ff[push_lv_ff]);
            if (rel_ff) begin
               state_in = ST_FINISH;
            end else begin
               cur_in   = cur_ff + LVW'(1);
               state_in = (cur_ff + LVW'(1) < lvl_ff) ? ST_SPLIT_RD : ST_AFLIP_RD;
            end
         end
         ST_AFLIP_RD: begin
            if (lvl_ff == '0) begin
               state_in = ST_ADONE;
            end else begin
               bm_raddr = node_at(lvl_ff - LVW'(1), pos_at(b_ff, eff_e, lvl_ff) >> 1);
               state_in = ST_AFLIP_WR;
            end
         end
         ST_AFLIP_WR: begin
            bm_we    = 1'b1;
            bm_waddr = node_at(lvl_ff - LVW'(1), pos_at(b_ff, eff_e, lvl_ff) >> 1);
            bm_wdata = bm_rdata ^ (2'b1 << bba_pkg::BIT_PAIR);
            state_in = ST_ADONE;
         end
         ST_ADONE: begin
            free_in      = free_ff - (region >> lvl_ff);
            res_addr_in  = base_ff + (64'(b_ff) << eff_s);
            res_ok_in    = 1'b1;
            res_bytes_in = region >> lvl_ff;
            state_in     = ST_FINISH;
         end
         ST_SL_RD: begin
            if (cur_ff == '0) begin
               if (func_ff == bba_pkg::FN_QUERY) begin
                  res_ok_in    = 1'b1;
                  res_bytes_in = region;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_REL_INIT;
               end
            end else begin
               bm_raddr = node_at(cur_ff - LVW'(1), pos_at(b_ff, eff_e, cur_ff - LVW'(1)));
               state_in = ST_SL_CHK;
            end
         end
         ST_SL_CHK: begin
            if (bm_rdata[bba_pkg::BIT_SPLIT]) begin
               if (func_ff == bba_pkg::FN_QUERY) begin
                  res_ok_in    = 1'b1;
                  res_bytes_in = region >> cur_ff;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_REL_INIT;
               end
            end else begin
               cur_in   = cur_ff - LVW'(1);
               state_in = ST_SL_RD;
            end
         end
         ST_REL_INIT: begin
            tsum         = 32'(free_ff) + 32'(region >> cur_ff);
            free_in      = (tsum > 32'(region)) ? region : tsum[30:0];
            res_ok_in    = 1'b1;
            res_bytes_in = region >> cur_ff;
            // drop offset bits below the block alignment
            baln = (b_ff >> (eff_e - cur_ff)) << (eff_e - cur_ff);
            b_in = baln;
            if (cur_ff == '0) begin
               push_b_in  = baln;
               push_lv_in = '0;
               rel_in     = 1'b1;
               state_in   = ST_PUSH_A;
            end else begin
               state_in = ST_REL_RD;
            end
         end
         ST_REL_RD: begin
            bm_raddr = node_at(cur_ff - LVW'(1), pos_at(b_ff, eff_e, cur_ff) >> 1);
            state_in = ST_REL_WR;
         end
         ST_REL_WR: begin
            bm_we    = 1'b1;
            bm_waddr = node_at(cur_ff - LVW'(1), pos_at(b_ff, eff_e, cur_ff) >> 1);
            if (!bm_rdata[bba_pkg::BIT_PAIR]) begin
               // buddy still in use: stop merging here
               bm_wdata   = bm_rdata | (2'b1 << bba_pkg::BIT_PAIR);
               push_b_in  = b_ff;
               push_lv_in = cur_ff;
               rel_in     = 1'b1;
               state_in   = ST_PUSH_A;
            end else begin
               bm_wdata = '0;
               state_in = ST_UNL_RD;
            end
         end
         ST_UNL_RD: begin
            nx_raddr = b_ff ^ span;
            pv_raddr = b_ff ^ span;
            state_in = ST_UNL_WR;
         end
         ST_UNL_WR: begin
            if (nx_rdata[IW]) begin
               pv_we    = 1'b1;
               pv_waddr = nx_rdata[IW-1:0];
               pv_wdata = pv_rdata;
            end
            if (pv_rdata[IW]) begin
               nx_we    = 1'b1;
               nx_waddr = pv_rdata[IW-1:0];
               nx_wdata = nx_rdata;
            end else begin
               heads_in[cur_ff] = nx_rdata;
            end
            cnt_in[cur_ff] = cnt_down(cnt_ff[cur_ff]);
            baln   = b_ff & ~span;
            b_in   = baln;
            cur_in = cur_ff - LVW'(1);
            if (cur_ff == LVW'(1)) begin
               push_b_in  = baln;
               push_lv_in = '0;
               rel_in     = 1'b1;
               state_in   = ST_PUSH_A;
            end else begin
               state_in = ST_REL_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_ok_in    = res_ok_ff;
               rsp_bytes_in = res_bytes_ff;
               rsp_free_in  = free_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      // a write to the base, leaf or levels register restores the whole region
      if (csr_we) begin
         case (csr_index)
            bba_pkg::CSR_BASE: begin
               base_in  = csr_wdata;
               state_in = ST_CLEAR;
               clr_in   = '0;
            end
            bba_pkg::CSR_LEAF: begin
               leaf_in  = csr_wdata[4:0];
               state_in = ST_CLEAR;
               clr_in   = '0;
            end
            bba_pkg::CSR_LEVELS: begin
               levels_in = csr_wdata[3:0];
               state_in  = ST_CLEAR;
               clr_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         base_ff      <= bba_pkg::BASE_RESET;
         leaf_ff      <= bba_pkg::LEAF_RESET;
         levels_ff    <= bba_pkg::LEVELS_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < L; i++) begin
            heads_ff[i] <= '0;
            cnt_ff[i]   <= '0;
         end
         free_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         leaf_ff      <= leaf_in;
         levels_ff    <= levels_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
         cnt_ff       <= cnt_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      req_ff       <= req_in;
      off_ff       <= off_in;
      flv_ff       <= flv_in;
      b_ff         <= b_in;
      lvl_ff       <= lvl_in;
      cur_ff       <= cur_in;
      p_ff         <= p_in;
      push_b_ff    <= push_b_in;
      push_lv_ff   <= push_lv_in;
      rel_ff       <= rel_in;
      res_addr_ff  <= res_addr_in;
      res_ok_ff    <= res_ok_in;
      res_bytes_ff <= res_bytes_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_free_ff  <= rsp_free_in;
   end

   bba_ram #(.WIDTH(2), .ADDR_W(IW)) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

   bba_ram #(.WIDTH(L), .ADDR_W(IW)) u_next (
      .clock (clock),
      .we    (nx_we),
      .waddr (nx_waddr),
      .wdata (nx_wdata),
      .raddr (nx_raddr),
      .rdata (nx_rdata)
   );

   bba_ram #(.WIDTH(L), .ADDR_W(IW)) u_prev (
      .clock (clock),
      .we    (pv_we),
      .waddr (pv_waddr),
      .wdata (pv_wdata),
      .raddr (pv_raddr),
      .rdata (pv_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_free_ff, rsp_bytes_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_ok_ff;

   `BBA_ASSERT_SAME(a_free_in_region, state_ff != ST_CLEAR, free_ff <= region)
   `BBA_ASSERT_NEXT(a_busy_after_transfer, req_tvalid && req_tready, !req_tready)
   `BBA_ASSERT_SAME(a_fail_clean, rsp_tvalid && !rsp_tuser[0],
                    rsp_tdata[63:0] == 64'd0 && rsp_tdata[94:64] == 31'd0)
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the buddy block allocator: directed cases, then random traffic.
module tb;
   localparam int LEVELS_MAX = 10;
   localparam int LEAF_COUNT = 1 << LEVELS_MAX;
   localparam int LINK_VALID = LEAF_COUNT;
   localparam int IDX_MASK = LEAF_COUNT - 1;
   localparam int COUNT_MAX = (1 << (LEVELS_MAX + 1)) - 1;
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      logic [63:0] address;
      logic        success;
      logic [30:0] block_bytes;
      logic [30:0] free_bytes;
   } outcome_type;

   typedef struct {
      logic [63:0] address;
      int          level;
      int          bytes;
   } block_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [63:0]  csr_wdata = '0;

   buddy_block_allocator DUT (.*);

   // allocator state as the bench sees it
   logic [63:0] region_base;
   int          leaf_bits_cfg, depth_cfg, depth, leaf_bits;
   bit          pair_map[LEAF_COUNT];
   bit          split_map[LEAF_COUNT];
   bit          link_written[LEAF_COUNT];
   int          heads[LEVELS_MAX + 1];
   int          next_of[LEAF_COUNT];
   int          prev_of[LEAF_COUNT];
   int          list_count[LEVELS_MAX + 1];
   int unsigned bytes_free;

   outcome_type awaited[$];
   block_type   live[$];
   int          errors = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          allocs_granted = 0;
   bit          no_idle = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(64'd80_000_000);
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned region_size();
      return 32'd1 << (leaf_bits + depth);
   endfunction

   function automatic int unsigned level_bytes(int lv);
      return region_size() >> lv;
   endfunction

   function automatic int node_at(int lv, int idx);
      return ((1 << lv) + idx - 1) & IDX_MASK;
   endfunction

   function automatic int pos_at(int b, int lv);
      return b >> (depth - lv);
   endfunction

   function automatic void rebuild_region();
      depth = depth_cfg > LEVELS_MAX ? LEVELS_MAX : depth_cfg;
      leaf_bits = leaf_bits_cfg;
      if (leaf_bits + depth > 30) leaf_bits = 30 - depth;
      for (int i = 0; i < LEAF_COUNT; i++) begin
         pair_map[i] = 0;
         split_map[i] = 0;
         link_written[i] = 0;
         next_of[i] = 0;
         prev_of[i] = 0;
      end
      for (int i = 0; i <= LEVELS_MAX; i++) begin
         heads[i] = 0;
         list_count[i] = 0;
      end
      heads[0] = LINK_VALID;
      link_written[0] = 1;
      list_count[0] = 1;
      bytes_free = region_size();
   endfunction

   function automatic void toggle_pair(int b, int lv);
      if (lv != 0) pair_map[node_at(lv - 1, pos_at(b, lv) >> 1)] ^= 1'b1;
   endfunction

   function automatic void push_free(int b, int lv);
      if (heads[lv] & LINK_VALID) prev_of[heads[lv] & IDX_MASK] = LINK_VALID | b;
      next_of[b] = heads[lv];
      prev_of[b] = 0;
      link_written[b] = 1;
      heads[lv] = LINK_VALID | b;
      if (list_count[lv] < COUNT_MAX) list_count[lv]++;
   endfunction

   function automatic int pop_free(int lv);
      int b, n;
      b = heads[lv] & IDX_MASK;
      n = next_of[b];
      if (n & LINK_VALID) prev_of[n & IDX_MASK] = 0;
      heads[lv] = n;
      if (list_count[lv] > 0) list_count[lv]--;
      return b;
   endfunction

   function automatic void unlink_free(int b, int lv);
      int n, p;
      n = next_of[b];
      p = prev_of[b];
      if (n & LINK_VALID) prev_of[n & IDX_MASK] = p;
      if (p & LINK_VALID) next_of[p & IDX_MASK] = n;
      else heads[lv] = n;
      if (list_count[lv] > 0) list_count[lv]--;
   endfunction

   function automatic int level_for_size(logic [30:0] req);
      longint unsigned s;
      int p, r;
      s = (req == 0) ? 1 : req;
      p = 0;
      r = leaf_bits + depth;
      while (p < 31 && (64'd1 << p) < s) p++;
      if (p > r) return -1;
      if (p < leaf_bits) return depth;
      return r - p;
   endfunction

   function automatic int level_from_splits(int b);
      for (int lv = depth; lv > 0; lv--)
         if (split_map[node_at(lv - 1, pos_at(b, lv - 1))]) return lv;
      return 0;
   endfunction

   function automatic void merge_up(int b, int lv);
      longint unsigned t;
      int span;
      t = bytes_free + level_bytes(lv);
      bytes_free = t > region_size() ? region_size() : 32'(t);
      b &= ~((1 << (depth - lv)) - 1);
      while (lv > 0) begin
         span = 1 << (depth - lv);
         toggle_pair(b, lv);
         if (pair_map[node_at(lv - 1, pos_at(b, lv) >> 1)]) break;
         unlink_free(b ^ span, lv);
         split_map[node_at(lv - 1, pos_at(b, lv - 1))] = 0;
         b &= ~span;
         lv--;
      end
      push_free(b, lv);
   endfunction

   // level a free or query would act on; -1 when it fails
   function automatic int target_level(logic [2:0] fn, logic [30:0] size, logic [63:0] addr,
                                       logic [3:0] flv);
      logic [63:0] off;
      int b;
      off = addr - region_base;
      if (fn < bba_pkg::FN_FREE_SPLIT || fn > bba_pkg::FN_QUERY || off >= region_size())
         return -1;
      b = int'(off >> leaf_bits) & IDX_MASK;
      if (fn == bba_pkg::FN_FREE_SPLIT || fn == bba_pkg::FN_QUERY)
         return level_from_splits(b);
      if (fn == bba_pkg::FN_FREE_SIZE) return level_for_size(size);
      return flv > depth ? -1 : int'(flv);
   endfunction

   // a merge must never unlink a block whose links were never written
   function automatic bit merge_is_safe(logic [63:0] addr, int lv);
      int b, span;
      b = int'((addr - region_base) >> leaf_bits) & IDX_MASK;
      b &= ~((1 << (depth - lv)) - 1);
      while (lv > 0) begin
         span = 1 << (depth - lv);
         if (!pair_map[node_at(lv - 1, pos_at(b, lv) >> 1)]) break;
         if (!link_written[b ^ span]) return 0;
         b &= ~span;
         lv--;
      end
      return 1;
   endfunction

   function automatic outcome_type predict_outcome(logic [2:0] fn, logic [30:0] size,
                                                   logic [63:0] addr, logic [3:0] flv);
      outcome_type o;
      int lv, src, b;
      bit found;
      o = '0;
      if (fn == bba_pkg::FN_ALLOC) begin
         lv = level_for_size(size);
         if (lv >= 0 && level_bytes(lv) <= bytes_free) begin
            found = 0;
            if (heads[lv] & LINK_VALID) begin
               b = pop_free(lv);
               found = 1;
            end else begin
               for (src = lv - 1; src >= 0; src--)
                  if (heads[src] & LINK_VALID) break;
               if (src >= 0) begin
                  b = pop_free(src);
                  for (int s = src; s < lv; s++) begin
                     split_map[node_at(s, pos_at(b, s))] = 1;
                     toggle_pair(b, s);
                     push_free(b + (1 << (depth - s - 1)), s + 1);
                  end
                  found = 1;
               end
            end
            if (found) begin
               toggle_pair(b, lv);
               bytes_free -= level_bytes(lv);
               o.address = region_base + (64'(b) << leaf_bits);
               o.block_bytes = 31'(level_bytes(lv));
               o.success = 1'b1;
            end
         end
      end else begin
         lv = target_level(fn, size, addr, flv);
         if (lv >= 0) begin
            if (fn != bba_pkg::FN_QUERY)
               merge_up(int'((addr - region_base) >> leaf_bits) & IDX_MASK, lv);
            o.block_bytes = 31'(level_bytes(lv));
            o.success = 1'b1;
         end
      end
      o.free_bytes = 31'(bytes_free);
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_request(logic [2:0] fn, logic [30:0] size, logic [63:0] addr,
                               logic [3:0] flv);
      int gap;
      outcome_type o;
      // keep frees from walking into links that were never set up
      if (fn >= bba_pkg::FN_FREE_SPLIT && fn <= bba_pkg::FN_FREE_LEVEL) begin
         gap = target_level(fn, size, addr, flv);
         if (gap >= 0 && !merge_is_safe(addr, gap)) fn = bba_pkg::FN_QUERY;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, flv, addr, size};
      req_tuser <= fn;
      do @(posedge clock); while (!req_tready);
      o = predict_outcome(fn, size, addr, flv);
      awaited.push_back(o);
      items_sent++;
      if (fn == bba_pkg::FN_ALLOC && o.success) begin
         allocs_granted++;
         live.push_back('{o.address, level_for_size(size), int'(o.block_bytes)});
      end
   endtask

   // result side: compare each transfer, then choose the next ready level
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (awaited.size() == 0) begin
            errors++;
            $error("result with nothing expected");
         end else begin
            want = awaited.pop_front();
            if (rsp_tdata[63:0] !== want.address) begin
               errors++;
               $error("result_address expected %h got %h", want.address, rsp_tdata[63:0]);
            end
            if (rsp_tuser[0] !== want.success) begin
               errors++;
               $error("success expected %0d got %0d", want.success, rsp_tuser[0]);
            end
            if (rsp_tdata[94:64] !== want.block_bytes) begin
               errors++;
               $error("block_bytes expected %0d got %0d", want.block_bytes, rsp_tdata[94:64]);
            end
            if (rsp_tdata[125:95] !== want.free_bytes) begin
               errors++;
               $error("free_bytes expected %0d got %0d", want.free_bytes, rsp_tdata[125:95]);
            end
         end
      end
      if (no_idle) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 60) rsp_tready <= 1'b1;
   end

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_region(logic [63:0] base, logic [63:0] shift, logic [63:0] lvls);
      drain();
      csr_we <= 1'b1;
      csr_index <= bba_pkg::CSR_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= bba_pkg::CSR_LEAF;
      csr_wdata <= shift;
      @(posedge clock);
      csr_index <= bba_pkg::CSR_LEVELS;
      csr_wdata <= lvls;
      @(posedge clock);
      csr_we <= 1'b0;
      region_base = base;
      leaf_bits_cfg = int'(shift[4:0]);
      depth_cfg = int'(lvls[3:0]);
      rebuild_region();
      live.delete();
   endtask

   task automatic test_directed();
      logic [63:0] top_address;
      send_request(bba_pkg::FN_ALLOC, 31'd0, '0, '0);
      send_request(bba_pkg::FN_ALLOC, 31'd1, '0, '0);
      send_request(bba_pkg::FN_ALLOC, 31'h7FFF_FFFF, '0, '0);
      send_request(bba_pkg::FN_ALLOC, 31'd1 << 30, '0, '0);
      send_request(bba_pkg::FN_QUERY, '0, region_base + 64'h1000, '0);
      send_request(bba_pkg::FN_FREE_SPLIT, '0, region_base, '0);
      send_request(bba_pkg::FN_FREE_SIZE, 31'd4096, region_base + 64'h1FFF, '0);
      // whole region: take it, then hand it back by level zero
      send_request(bba_pkg::FN_ALLOC, 31'd1 << 22, '0, '0);
      top_address = awaited[$].address;
      send_request(bba_pkg::FN_ALLOC, 31'd1, '0, '0);
      send_request(bba_pkg::FN_FREE_LEVEL, '0, top_address, 4'd0);
      send_request(bba_pkg::FN_FREE_LEVEL, '0, region_base, 4'd11);
      send_request(bba_pkg::FN_FREE_LEVEL, '0, region_base, 4'd15);
      send_request(bba_pkg::FN_FREE_SPLIT, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      send_request(bba_pkg::FN_QUERY, '0, region_base + (64'd1 << 22), '0);
      send_request(bba_pkg::FN_FREE_SIZE, 31'h7FFF_FFFF, region_base, '0);
      for (int k = 1; k <= 3; k++)
         send_request(bba_pkg::FN_QUERY + 3'(k), 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      4'hF);
      send_request(bba_pkg::FN_ALLOC, 31'd1 << 21, '0, '0);
      send_request(bba_pkg::FN_ALLOC, 31'd5000, '0, '0);
      send_request(bba_pkg::FN_FREE_SPLIT, '0, live[0].address, '0);
   endtask

   task automatic test_random_traffic(int count);
      int r, lv, pick;
      int unsigned bytes;
      logic [30:0] size;
      logic [2:0] fn;
      block_type blk;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 4) no_idle = !no_idle;
         r = $urandom_range(0, 99);
         if (r < 45 || (r < 85 && live.size() == 0)) begin
            if ($urandom_range(0, 9) == 0) lv = $urandom_range(0, depth);
            else lv = depth - $urandom_range(0, depth < 3 ? depth : 3);
            bytes = level_bytes(lv);
            size = 31'((bytes >> 1) + 1 + ($urandom % (bytes - (bytes >> 1))));
            if ($urandom_range(0, 19) == 0) size = 31'($urandom);
            send_request(bba_pkg::FN_ALLOC, size, '0, '0);
         end else if (r < 85) begin
            pick = $urandom_range(0, live.size() - 1);
            blk = live[pick];
            live.delete(pick);
            fn = 3'($urandom_range(bba_pkg::FN_FREE_SPLIT, bba_pkg::FN_FREE_LEVEL));
            size = (blk.bytes > 2 && $urandom_range(0, 1)) ? 31'(blk.bytes - 1)
                                                           : 31'(blk.bytes);
            send_request(fn, size, blk.address + ($urandom % blk.bytes),
                         4'(blk.level));
         end else begin
            // noise: any code, stray addresses and sizes, misuse frees
            fn = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 1))
               send_request(fn, 31'($urandom),
                            region_base + ($urandom % (2 * region_size())),
                            4'($urandom));
            else
               send_request(fn, 31'($urandom), {$urandom, $urandom}, 4'($urandom));
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_region_settings();
      program_region({$urandom, $urandom}, 64'd0, 64'd0);
      test_random_traffic(60);
      program_region({$urandom, $urandom}, 64'd20, 64'd10);
      test_random_traffic(300);
      program_region({$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom});
      test_random_traffic(300);
      program_region(64'hFFFF_FFFF_FFFF_F000, 64'd3, 64'd4);
      test_random_traffic(300);
      program_region({$urandom, $urandom}, 64'd0, 64'd10);
      test_random_traffic(300);
      program_region({$urandom, $urandom}, 64'($urandom_range(0, 31)),
                     64'($urandom_range(0, 15)));
      test_random_traffic(150);
   endtask

   initial begin
      region_base = bba_pkg::BASE_RESET;
      leaf_bits_cfg = int'(bba_pkg::LEAF_RESET);
      depth_cfg = int'(bba_pkg::LEVELS_RESET);
      rebuild_region();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(300);
      test_region_settings();
      drain();
      $display("covered %0d requests over seven region settings, %0d allocations granted",
               items_sent, allocs_granted);
      $display("checked %0d results field by field", results_seen);
      if (errors == 0 && awaited.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/buddy_block_allocator.sv
bench/tb.sv
